[rtl/dlb_pkg.sv]
// ----------------------------------------------------------------------------
// dlb_pkg
// shared types, constants and helpers of the daylight lamp brightness unit
// ----------------------------------------------------------------------------
package dlb_pkg;

    localparam int NOON_MINUTE      = 720;
    localparam int FADE_MINUTES     = 30;
    localparam int MIN_PER_HOUR     = 60;
    localparam int RESULT_CAP       = 32;
    localparam int FRAC_BITS        = 16;
    localparam int MAX_DAY_LAMPS_DEF   = 16;
    localparam int MAX_NIGHT_LAMPS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // lamp counts up to the result cap
    localparam int CNT_W = 6;

    // shared divider sizing
    localparam int DIV_NUM_W = 36;
    localparam int DIV_DEN_W = 11;

    // reciprocal of the fade length, exact for products below 8192
    localparam int RECIP30       = 8739;
    localparam int RECIP30_SHIFT = 18;

    // register indexes
    localparam logic [2:0] REG_SUNRISE     = 3'd0;
    localparam logic [2:0] REG_SUNSET      = 3'd1;
    localparam logic [2:0] REG_MAX_BRIGHT  = 3'd2;
    localparam logic [2:0] REG_NIGHT_BRIGHT = 3'd3;
    localparam logic [2:0] REG_NIGHT_COLOR = 3'd4;
    localparam logic [2:0] REG_DAY_COUNT   = 3'd5;
    localparam logic [2:0] REG_NIGHT_COUNT = 3'd6;

    localparam logic [10:0] SUNRISE_RESET = 11'd360;
    localparam logic [10:0] SUNSET_RESET  = 11'd1080;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       shutdown;
    } dlb_in_t;

    typedef struct packed {
        logic       lamp_group;
        logic [3:0] lamp_index;
        logic [7:0] level;
        logic       switch_off;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } dlb_out_t;

    typedef struct packed {
        logic [10:0] sunrise_minute;
        logic [10:0] sunset_minute;
        logic [7:0]  max_brightness;
        logic [7:0]  night_brightness;
        logic [23:0] night_color;
        logic [4:0]  day_lamp_count;
        logic [4:0]  night_lamp_count;
    } dlb_cfg_t;

    // one time item, classified and ready to be expanded into commands
    typedef struct packed {
        logic             shutdown;
        logic [CNT_W-1:0] day_cnt;
        logic [CNT_W-1:0] night_cnt;
        logic             a_ok;
        logic [4:0]       a_idx;
        logic [7:0]       a_lvl;
        logic             b_ok;
        logic [4:0]       b_idx;
        logic [7:0]       b_lvl;
        logic [7:0]       night_lvl;
        logic [23:0]      color;
    } dlb_job_t;

    // floor(x / 30) for x below 7680
    function automatic logic [7:0] div30(input logic [12:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'(RECIP30);
        return p[RECIP30_SHIFT+7:RECIP30_SHIFT];
    endfunction

endpackage

[rtl/daylight_lamp_brightness_unit.sv]
// ----------------------------------------------------------------------------
// daylight_lamp_brightness_unit
// turns time of day items into day and night lamp commands
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  time      in         time_valid/time_ready   time_item (hour, minute, shutdown)
//  cmd       out        cmd_valid/cmd_ready     cmd_item (one lamp command)
//  config    in         apb psel/penable        paddr, pwdata, prdata
//
//  a time item passes through the front in order: the minute of day,
//  operand set up, the two radix-4 dividers (18 steps each), the lamp
//  level multiplies, and the push of the job into the queue
//  the back sends one lamp command per cycle while cmd_ready is high,
//  up to 32 for one time item, and the front already works on the next one
//  reset is asynchronous and clears all control state, registers take
//  their documented reset values
//  a stalled cmd side fills the two-entry job queue, holds the front in
//  its push state, then fills the input buffer, and only then drops
//  time_ready
// ----------------------------------------------------------------------------
module daylight_lamp_brightness_unit
    import dlb_pkg::*;
#(
    parameter int MAX_DAY_LAMPS   = MAX_DAY_LAMPS_DEF,
    parameter int MAX_NIGHT_LAMPS = MAX_NIGHT_LAMPS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // time items
    input  logic        time_valid,
    output logic        time_ready,
    input  dlb_in_t     time_item,
    // lamp commands
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output dlb_out_t    cmd_item
);

    dlb_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes, unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sunrise_minute   <= SUNRISE_RESET;
            cfg_reg.sunset_minute    <= SUNSET_RESET;
            cfg_reg.max_brightness   <= '0;
            cfg_reg.night_brightness <= '0;
            cfg_reg.night_color      <= '0;
            cfg_reg.day_lamp_count   <= '0;
            cfg_reg.night_lamp_count <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SUNRISE:      cfg_reg.sunrise_minute   <= pwdata[10:0];
                REG_SUNSET:       cfg_reg.sunset_minute    <= pwdata[10:0];
                REG_MAX_BRIGHT:   cfg_reg.max_brightness   <= pwdata[7:0];
                REG_NIGHT_BRIGHT: cfg_reg.night_brightness <= pwdata[7:0];
                REG_NIGHT_COLOR:  cfg_reg.night_color      <= pwdata[23:0];
                REG_DAY_COUNT:    cfg_reg.day_lamp_count   <= pwdata[4:0];
                REG_NIGHT_COUNT:  cfg_reg.night_lamp_count <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_SUNRISE:      prdata = 32'(cfg_reg.sunrise_minute);
            REG_SUNSET:       prdata = 32'(cfg_reg.sunset_minute);
            REG_MAX_BRIGHT:   prdata = 32'(cfg_reg.max_brightness);
            REG_NIGHT_BRIGHT: prdata = 32'(cfg_reg.night_brightness);
            REG_NIGHT_COLOR:  prdata = 32'(cfg_reg.night_color);
            REG_DAY_COUNT:    prdata = 32'(cfg_reg.day_lamp_count);
            REG_NIGHT_COUNT:  prdata = 32'(cfg_reg.night_lamp_count);
            default:          prdata = '0;
        endcase
    end

    // front classifies, queue decouples, back expands
    logic     fq_valid, fq_ready, qb_valid, qb_ready;
    dlb_job_t fq_job, qb_job;

    dlb_front #(
        .MAX_DAY_LAMPS   (MAX_DAY_LAMPS),
        .MAX_NIGHT_LAMPS (MAX_NIGHT_LAMPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .time_valid (time_valid),
        .time_ready (time_ready),
        .time_item  (time_item),
        .job_valid  (fq_valid),
        .job_ready  (fq_ready),
        .job        (fq_job)
    );

    dlb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    dlb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item)
    );

endmodule

[rtl/dlb_div.sv]
// ----------------------------------------------------------------------------
// dlb_div
// unsigned restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module dlb_div
    import dlb_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int STEPS = NUM_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < 2; i++)
        begin
            rem_next = {rem_next[DEN_W-1:0], quo_next[NUM_W-1]};
            quo_next = {quo_next[NUM_W-2:0], 1'b0};
            if (rem_next >= {1'b0, den_reg})
            begin
                rem_next    = rem_next - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STEP_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[rtl/dlb_front.sv]
// ----------------------------------------------------------------------------
// dlb_front
// takes time items, works out brightness, sun position and night fade
// ----------------------------------------------------------------------------
module dlb_front
    import dlb_pkg::*;
#(
    parameter int MAX_DAY_LAMPS   = MAX_DAY_LAMPS_DEF,
    parameter int MAX_NIGHT_LAMPS = MAX_NIGHT_LAMPS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  dlb_cfg_t cfg,
    input  logic     time_valid,
    output logic     time_ready,
    input  dlb_in_t  time_item,
    output logic     job_valid,
    input  logic     job_ready,
    output dlb_job_t job
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       buf_valid_reg;
    dlb_in_t    buf_reg;
    logic [10:0] m_reg;
    logic        sd_reg;

    // lamp limits
    logic [CNT_W-1:0] lamps;
    logic [CNT_W-1:0] nights;
    assign lamps = (6'(cfg.day_lamp_count) > 6'(MAX_DAY_LAMPS))
                 ? 6'(MAX_DAY_LAMPS) : 6'(cfg.day_lamp_count);
    assign nights = (6'(cfg.night_lamp_count) > 6'(MAX_NIGHT_LAMPS))
                  ? 6'(MAX_NIGHT_LAMPS) : 6'(cfg.night_lamp_count);

    // brightness operands
    logic        case_a, case_b;
    logic [10:0] span, bden_raw;
    logic [18:0] bprod;
    logic [DIV_NUM_W-1:0] bnum;
    logic [DIV_DEN_W-1:0] bden;
    assign case_a = (m_reg <= 11'(NOON_MINUTE)) && (m_reg > cfg.sunrise_minute);
    assign case_b = (m_reg > 11'(NOON_MINUTE)) && (m_reg < cfg.sunset_minute);
    assign span = case_a ? m_reg - cfg.sunrise_minute : cfg.sunset_minute - m_reg;
    assign bden_raw = case_a ? 11'(NOON_MINUTE) - cfg.sunrise_minute
                             : cfg.sunset_minute - 11'(NOON_MINUTE);
    assign bprod = 19'(cfg.max_brightness) * 19'(span);
    assign bnum = (case_a || case_b) ? DIV_NUM_W'({bprod, 16'd0}) : '0;
    assign bden = (case_a || case_b) ? bden_raw : DIV_DEN_W'(1);

    // sun position operands, sign and magnitude
    logic        d_pos, m_pos, valid_u;
    logic [10:0] dmag, mmag;
    logic [16:0] uprod;
    logic [DIV_NUM_W-1:0] unum;
    logic [DIV_DEN_W-1:0] uden;
    assign d_pos = cfg.sunset_minute >= cfg.sunrise_minute;
    assign m_pos = m_reg >= cfg.sunrise_minute;
    assign dmag = d_pos ? cfg.sunset_minute - cfg.sunrise_minute
                        : cfg.sunrise_minute - cfg.sunset_minute;
    assign mmag = m_pos ? m_reg - cfg.sunrise_minute : cfg.sunrise_minute - m_reg;
    assign valid_u = (lamps > 6'd1) && (dmag != 11'd0);
    assign uprod = 17'(mmag) * 17'(lamps - 6'd1);
    assign unum = valid_u ? DIV_NUM_W'({uprod, 16'd0}) : '0;
    assign uden = valid_u ? dmag : DIV_DEN_W'(1);

    // night window and fade factors
    logic [11:0] mp30;
    logic        near_set, early, fade1, fade2;
    logic [10:0] k1, k2;
    logic [4:0]  f1, f2;
    assign mp30 = {1'b0, m_reg} + 12'(FADE_MINUTES);
    assign near_set = mp30 > {1'b0, cfg.sunset_minute};
    assign early = mp30 < {1'b0, cfg.sunrise_minute};
    assign fade1 = near_set && (cfg.sunset_minute > m_reg);
    assign fade2 = ({1'b0, m_reg} < {1'b0, cfg.sunrise_minute} + 12'(FADE_MINUTES))
                && (m_reg > cfg.sunrise_minute);
    assign k1 = cfg.sunset_minute - m_reg;
    assign k2 = m_reg - cfg.sunrise_minute;
    assign f1 = fade1 ? 5'(FADE_MINUTES) - k1[4:0] : 5'(FADE_MINUTES);
    assign f2 = fade2 ? 5'(FADE_MINUTES) - k2[4:0] : 5'(FADE_MINUTES);

    logic        valid_u_reg, neg_reg, night_en_reg;
    logic [4:0]  f2_reg;
    logic [12:0] p1_reg, p2_reg;
    logic [7:0]  l1_reg, l2_reg;

    // dividers
    logic start;
    logic done_b, done_u;
    logic [DIV_NUM_W-1:0] quo_b, quo_u;
    assign start = (state_reg == ST_LOAD);

    dlb_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_bright (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (bnum),
        .den   (bden),
        .done  (done_b),
        .quo   (quo_b)
    );

    dlb_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (unum),
        .den   (uden),
        .done  (done_u),
        .quo   (quo_u)
    );

    // job assembly
    logic [23:0] bri;
    logic        dlc_zero, day_en;
    logic [CNT_W-1:0] day_cnt, room, ncap;
    logic [19:0] hi;
    logic [15:0] lo;
    logic [16:0] fa;
    logic [40:0] pa;
    logic [39:0] pb;
    dlb_job_t    job_reg, job_new;

    assign bri = quo_b[23:0];
    assign dlc_zero = (cfg.day_lamp_count == 5'd0);
    assign day_en = (bri != 24'd0) || sd_reg;
    assign day_cnt = (dlc_zero || !day_en) ? '0 : lamps;
    assign room = 6'(RESULT_CAP) - day_cnt;
    assign ncap = (nights > room) ? room : nights;
    assign hi = quo_u[DIV_NUM_W-1:FRAC_BITS];
    assign lo = quo_u[FRAC_BITS-1:0];
    assign fa = 17'h10000 - {1'b0, lo};
    assign pa = 41'(fa) * 41'(bri);
    assign pb = 40'(lo) * 40'(bri);

    always_comb
    begin
        job_new           = '0;
        job_new.shutdown  = sd_reg;
        job_new.day_cnt   = day_cnt;
        job_new.night_cnt = (dlc_zero || !night_en_reg) ? '0 : ncap;
        job_new.a_ok      = valid_u_reg && (neg_reg ? (hi == 20'd0) : (hi < 20'(lamps)));
        job_new.a_idx     = neg_reg ? 5'd0 : hi[4:0];
        job_new.a_lvl     = pa[39:32];
        job_new.b_ok      = valid_u_reg && !neg_reg && (hi < 20'(lamps - 6'd1));
        job_new.b_idx     = hi[4:0] + 5'd1;
        job_new.b_lvl     = pb[39:32];
        job_new.night_lvl = l2_reg;
        job_new.color     = cfg.night_color;
    end

    logic job_has;
    assign job_has = (job_reg.day_cnt != '0) || (job_reg.night_cnt != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (buf_valid_reg)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_DIV;
            ST_DIV:
                if (done_b && done_u)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_PUSH;
            ST_PUSH:
                if (!job_has || job_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (time_valid && time_ready)
                buf_valid_reg <= 1'b1;
            else if (state_reg == ST_IDLE && buf_valid_reg)
                buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (time_valid && time_ready)
            buf_reg <= time_item;
        if (state_reg == ST_IDLE && buf_valid_reg)
        begin
            m_reg  <= 11'(buf_reg.hour) * 11'(MIN_PER_HOUR) + 11'(buf_reg.minute);
            sd_reg <= buf_reg.shutdown;
        end
        if (state_reg == ST_LOAD)
        begin
            valid_u_reg  <= valid_u;
            neg_reg      <= (!m_pos) ^ (!d_pos);
            night_en_reg <= near_set || early || sd_reg;
            f2_reg       <= f2;
            p1_reg       <= 13'(cfg.night_brightness) * 13'(f1);
        end
        // fade chain settles while the dividers run
        l1_reg <= div30(p1_reg);
        p2_reg <= 13'(l1_reg) * 13'(f2_reg);
        l2_reg <= div30(p2_reg);
        if (state_reg == ST_MUL)
            job_reg <= job_new;
    end

    assign time_ready = !buf_valid_reg;
    assign job_valid  = (state_reg == ST_PUSH) && job_has;
    assign job        = job_reg;

endmodule

[rtl/dlb_queue.sv]
// ----------------------------------------------------------------------------
// dlb_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module dlb_queue
    import dlb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  dlb_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output dlb_job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dlb_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/dlb_back.sv]
// ----------------------------------------------------------------------------
// dlb_back
// expands one job into its day and night lamp commands
// ----------------------------------------------------------------------------
module dlb_back
    import dlb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  dlb_job_t job,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output dlb_out_t cmd_item
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] total, night_idx;
    logic             cmd_valid_reg;
    dlb_out_t         cmd_reg, cmd_new;
    logic             load, is_last, is_day;

    assign total     = job.day_cnt + job.night_cnt;
    assign is_last   = (cnt_reg == total - 1'b1);
    assign is_day    = (cnt_reg < job.day_cnt);
    assign night_idx = cnt_reg - job.day_cnt;
    assign load      = job_valid && (!cmd_valid_reg || cmd_ready);
    assign job_ready = load && is_last;

    always_comb
    begin
        cmd_new            = '0;
        cmd_new.switch_off = job.shutdown;
        cmd_new.last       = is_last;
        if (is_day)
        begin
            cmd_new.lamp_group = 1'b0;
            cmd_new.lamp_index = cnt_reg[3:0];
            if (job.a_ok && cnt_reg[4:0] == job.a_idx)
                cmd_new.level = job.a_lvl;
            else if (job.b_ok && cnt_reg[4:0] == job.b_idx)
                cmd_new.level = job.b_lvl;
        end
        else
        begin
            cmd_new.lamp_group = 1'b1;
            cmd_new.lamp_index = night_idx[3:0];
            cmd_new.level      = job.night_lvl;
            cmd_new.red        = job.color[23:16];
            cmd_new.green      = job.color[15:8];
            cmd_new.blue       = job.color[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                cnt_reg <= is_last ? '0 : cnt_reg + 1'b1;
            if (load)
                cmd_valid_reg <= 1'b1;
            else if (cmd_ready)
                cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= cmd_new;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_item  = cmd_reg;

endmodule

[rtl/dlb_checker.sv]
// ----------------------------------------------------------------------------
// dlb_checker
// port level checks of the daylight lamp brightness unit
// ----------------------------------------------------------------------------
module dlb_checker
    import dlb_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     pready,
    input logic     cmd_valid,
    input logic     cmd_ready,
    input dlb_out_t cmd_item
);

    // a stalled command holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_item))
        else $error("stalled command changed");

    // day lamps carry no color
    a_day_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_item.lamp_group |->
            cmd_item.red == 8'd0 && cmd_item.green == 8'd0 && cmd_item.blue == 8'd0)
        else $error("day lamp command with color");

    // config port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // no command right out of reset
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !cmd_valid)
        else $error("command valid out of reset");

endmodule

bind daylight_lamp_brightness_unit dlb_checker u_dlb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the daylight lamp brightness unit against a behavioral predictor
// ----------------------------------------------------------------------------
// time items are driven from a queue with random gaps, lamp commands are
// taken with random stalls, and every command is compared field by field
// with the oldest predicted command; the configuration is changed between
// phases over the apb port while the unit is idle
// ----------------------------------------------------------------------------
module testbench
    import dlb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        time_valid;
    logic        time_ready;
    dlb_in_t     time_item;
    logic        cmd_valid;
    logic        cmd_ready;
    dlb_out_t    cmd_item;

    // predictor copy of the registers
    logic [10:0] sunrise_q;
    logic [10:0] sunset_q;
    logic [7:0]  max_bright_q;
    logic [7:0]  night_bright_q;
    logic [23:0] night_color_q;
    logic [4:0]  day_count_q;
    logic [4:0]  night_count_q;

    dlb_in_t  pending_times[$];
    dlb_out_t expected_cmds[$];

    int  mismatch_count;
    int  idle_cycles;
    bit  calm;          // no idling in the last part of the run
    int  send_gap;
    int  take_stall;
    int  stretch;

    daylight_lamp_brightness_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .time_valid (time_valid),
        .time_ready (time_ready),
        .time_item  (time_item),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_item   (cmd_item)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // fade over the last minutes before sunset or first after sunrise
    function automatic longint fade_level(input longint lvl, input longint k);
        return (lvl * (FADE_MINUTES - k)) / FADE_MINUTES;
    endfunction

    // expand one time item into the lamp commands it should produce
    function automatic void predict_commands(input dlb_in_t t);
        longint   m;
        longint   sr;
        longint   ss;
        longint   maxb;
        longint   bri;
        longint   lamps;
        longint   nights;
        longint   d;
        longint   u;
        longint   diff;
        longint   lvl;
        longint   nlvl;
        bit       sun_ok;
        int       produced;
        dlb_out_t c;
        m = longint'(t.hour) * 60 + longint'(t.minute);
        sr = longint'(sunrise_q);
        ss = longint'(sunset_q);
        maxb = longint'(max_bright_q);
        bri = 0;
        produced = 0;
        if (day_count_q == 0)
            return;
        if (m <= NOON_MINUTE && m > sr)
            bri = (maxb * (m - sr) * 65536) / (NOON_MINUTE - sr);
        else if (m > NOON_MINUTE && m < ss)
            bri = (maxb * (ss - m) * 65536) / (ss - NOON_MINUTE);
        lamps = longint'(day_count_q);
        if (lamps > 16)
            lamps = 16;
        if (bri != 0 || t.shutdown)
        begin
            d = ss - sr;
            u = 0;
            sun_ok = (lamps > 1) && (d != 0);
            if (sun_ok)
                u = ((m - sr) * (lamps - 1) * 65536) / d;
            for (longint n = 0; n < lamps; n++)
            begin
                lvl = 0;
                if (sun_ok)
                begin
                    diff = u - n * 65536;
                    if (diff < 0)
                        diff = -diff;
                    if (diff < 65536)
                        lvl = ((65536 - diff) * bri) >>> 32;
                end
                c = '0;
                c.lamp_group = 1'b0;
                c.lamp_index = n[3:0];
                c.level = lvl[7:0];
                c.switch_off = t.shutdown;
                expected_cmds.push_back(c);
                produced++;
            end
        end
        if (m + FADE_MINUTES > ss || m < sr - FADE_MINUTES || t.shutdown)
        begin
            nlvl = longint'(night_bright_q);
            nights = longint'(night_count_q);
            if (nights > 16)
                nights = 16;
            if (nights > RESULT_CAP - produced)
                nights = RESULT_CAP - produced;
            if (m + FADE_MINUTES > ss && ss - m > 0)
                nlvl = fade_level(nlvl, ss - m);
            if (m - FADE_MINUTES < sr && m - sr > 0)
                nlvl = fade_level(nlvl, m - sr);
            for (longint n = 0; n < nights; n++)
            begin
                c = '0;
                c.lamp_group = 1'b1;
                c.lamp_index = n[3:0];
                c.level = nlvl[7:0];
                c.switch_off = t.shutdown;
                c.red = night_color_q[23:16];
                c.green = night_color_q[15:8];
                c.blue = night_color_q[7:0];
                expected_cmds.push_back(c);
                produced++;
            end
        end
        if (produced > 0)
            expected_cmds[expected_cmds.size() - 1].last = 1'b1;
    endfunction

    // apb write: setup cycle then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SUNRISE:      sunrise_q      = value[10:0];
            REG_SUNSET:       sunset_q       = value[10:0];
            REG_MAX_BRIGHT:   max_bright_q   = value[7:0];
            REG_NIGHT_BRIGHT: night_bright_q = value[7:0];
            REG_NIGHT_COLOR:  night_color_q  = value[23:0];
            REG_DAY_COUNT:    day_count_q    = value[4:0];
            REG_NIGHT_COUNT:  night_count_q  = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int sr, input int ss, input int maxb, input int nb,
                              input int color, input int dc, input int nc);
        write_reg(REG_SUNRISE, sr);
        write_reg(REG_SUNSET, ss);
        write_reg(REG_MAX_BRIGHT, maxb);
        write_reg(REG_NIGHT_BRIGHT, nb);
        write_reg(REG_NIGHT_COLOR, color);
        write_reg(REG_DAY_COUNT, dc);
        write_reg(REG_NIGHT_COUNT, nc);
    endtask

    // let the queue drain, then wait out the front latency
    task automatic wait_idle();
        while (pending_times.size() != 0 || expected_cmds.size() != 0 || time_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic dlb_in_t pick_time(input bit legal);
        dlb_in_t t;
        if (legal)
        begin
            t.hour = 5'($urandom_range(0, 23));
            t.minute = 6'($urandom_range(0, 59));
        end
        else
        begin
            t.hour = 5'($urandom);
            t.minute = 6'($urandom);
        end
        t.shutdown = ($urandom_range(0, 7) == 0);
        return t;
    endfunction

    task automatic queue_time(input int hh, input int mm, input bit sd);
        dlb_in_t t;
        t.hour = hh[4:0];
        t.minute = mm[5:0];
        t.shutdown = sd;
        pending_times.push_back(t);
    endtask

    // random phase: items mostly around sunrise, noon and sunset
    task automatic random_phase(input int count);
        dlb_in_t t;
        int      mm;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: t = pick_time($urandom_range(0, 9) != 0);
                1:
                begin
                    mm = int'(sunrise_q) + $urandom_range(0, 80) - 40;
                    if (mm < 0) mm = 0;
                    t = pick_time(1'b1);
                    t.hour = 5'((mm / 60) % 32);
                    t.minute = 6'(mm % 60);
                end
                2:
                begin
                    mm = int'(sunset_q) + $urandom_range(0, 80) - 40;
                    if (mm < 0) mm = 0;
                    t = pick_time(1'b1);
                    t.hour = 5'((mm / 60) % 32);
                    t.minute = 6'(mm % 60);
                end
                default:
                begin
                    t = pick_time(1'b1);
                    t.hour = 5'($urandom_range(8, 16));
                end
            endcase
            pending_times.push_back(t);
        end
        wait_idle();
    endtask

    // driver: feeds time items from the queue with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_valid <= 1'b0;
            time_item  <= '0;
            send_gap   <= 0;
        end
        else if (!time_valid || time_ready)
        begin
            if (time_valid && time_ready)
                predict_commands(time_item);
            if (send_gap > 0)
            begin
                send_gap   <= send_gap - 1;
                time_valid <= 1'b0;
            end
            else if (pending_times.size() != 0)
            begin
                time_item  <= pending_times.pop_front();
                time_valid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 15);
            end
            else
                time_valid <= 1'b0;
        end
    end

    // monitor: takes lamp commands with random stalls and checks them
    always @(posedge clk or negedge rst_n)
    begin
        dlb_out_t want;
        if (!rst_n)
        begin
            cmd_ready  <= 1'b0;
            take_stall <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected command %p", cmd_item);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (cmd_item !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("command mismatch: expected %p actual %p",
                                     want, cmd_item);
                    end
                end
            end
            if (take_stall > 0)
            begin
                take_stall <= take_stall - 1;
                cmd_ready  <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                take_stall <= $urandom_range(1, 15);
                cmd_ready  <= 1'b0;
            end
            else
                cmd_ready <= 1'b1;
        end
    end

    // watchdog: cycles with no item accepted on either channel
    always @(posedge clk)
    begin
        if ((time_valid && time_ready) || (cmd_valid && cmd_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        sunrise_q = SUNRISE_RESET;
        sunset_q = SUNSET_RESET;
        max_bright_q = '0;
        night_bright_q = '0;
        night_color_q = '0;
        day_count_q = '0;
        night_count_q = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset values: no day lamps, nothing comes out
        queue_time(12, 0, 1'b0);
        queue_time(3, 0, 1'b1);
        wait_idle();

        // directed: extremes, fades, shutdown, single lamp, field extremes
        set_config(360, 1080, 255, 255, 24'hFFFFFF, 16, 16);
        queue_time(0, 0, 1'b0);
        queue_time(23, 59, 1'b0);
        queue_time(31, 63, 1'b0);
        queue_time(12, 0, 1'b0);
        queue_time(6, 0, 1'b0);
        queue_time(6, 1, 1'b0);
        queue_time(6, 15, 1'b0);
        queue_time(5, 29, 1'b0);
        queue_time(17, 31, 1'b0);
        queue_time(17, 50, 1'b0);
        queue_time(18, 0, 1'b0);
        queue_time(9, 30, 1'b1);
        queue_time(21, 42, 1'b1);
        wait_idle();
        set_config(360, 1080, 200, 100, 24'h123456, 1, 3);
        queue_time(10, 0, 1'b0);
        queue_time(19, 0, 1'b0);
        wait_idle();
        // sunset equal to sunrise, then sunset before sunrise
        set_config(600, 600, 255, 80, 24'hA5005A, 5, 2);
        queue_time(8, 0, 1'b0);
        queue_time(10, 20, 1'b1);
        wait_idle();
        set_config(900, 300, 128, 60, 24'h00FF00, 31, 31);
        queue_time(4, 50, 1'b0);
        queue_time(13, 0, 1'b0);
        queue_time(15, 10, 1'b1);
        wait_idle();

        // random phases over several settings
        set_config(360, 1080, 255, 255, 24'hFFFFFF, 16, 16);
        random_phase(70);
        set_config(0, 1439, 255, 0, 24'h000000, 2, 0);
        random_phase(50);
        set_config(2047, 2047, 0, 255, 24'hFFFFFF, 0, 31);
        random_phase(10);
        for (int p = 0; p < 4; p++)
        begin
            set_config($urandom_range(240, 600), $urandom_range(840, 1300),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 24'hFFFFFF), $urandom_range(1, 31),
                       $urandom_range(0, 31));
            random_phase(45);
        end
        // last part with no idling
        calm = 1'b1;
        set_config(300, 1200, 255, 200, 24'h5A5AA5, 16, 16);
        random_phase(50);

        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[files.f]
rtl/dlb_pkg.sv
rtl/dlb_div.sv
rtl/dlb_front.sv
rtl/dlb_queue.sv
rtl/dlb_back.sv
rtl/daylight_lamp_brightness_unit.sv
rtl/dlb_checker.sv
test/testbench.sv
